FILE: src/mpool_pkg.sv
// ----------------------------------------------------------------------------
// mpool_pkg
// types, codes and constants shared by the max pooling block
// ----------------------------------------------------------------------------
`default_nettype none

package mpool_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_ROWS     = 32;
   localparam int MAX_COLS     = 32;
   localparam int MAX_KERNEL   = 8;

   localparam int CH_W   = 3;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 5;
   localparam int KIDX_W = 3;
   localparam int PL_AW  = ROW_W + COL_W;
   localparam int ALL_AW = CH_W + ROW_W + COL_W;

   localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] ACC_MIN = -24'sh800000;

   typedef enum logic [1:0] {
      ACT_FWD  = 2'd0,
      ACT_BWD  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EXCEEDS = 2'd1,
      ST_NO_FWD  = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_KROWS  = 3'd0,
      REG_KCOLS  = 3'd1,
      REG_STEP   = 3'd2,
      REG_PROWS  = 3'd3,
      REG_PCOLS  = 3'd4,
      REG_PCOUNT = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_ERR,
      OP_PIX,
      OP_PIX_ERR,
      OP_WALK,
      OP_BWD,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CLASS,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_EXEC,
      B_WALK,
      B_WEND,
      B_WSAVE,
      B_BWD_A,
      B_BWD_B,
      B_RD
   } back_state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [CH_W-1:0]    channel;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [23:0] result_value;
      logic [CH_W-1:0]    res_channel;
      logic [ROW_W-1:0]   win_row;
      logic [COL_W-1:0]   win_col;
      logic [ROW_W-1:0]   arg_row;
      logic [COL_W-1:0]   arg_col;
   } rsp_type;

   typedef struct packed {
      logic [3:0] kr;
      logic [3:0] kc;
      logic [3:0] st;
      logic [5:0] pr;
      logic [5:0] pc;
      logic [3:0] pn;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      status_type         status;
      logic [CH_W-1:0]    channel;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic signed [15:0] sample;
      logic [ROW_W-1:0]   brow;
      logic [COL_W-1:0]   bcol;
      logic [ROW_W-1:0]   orow;
      logic [COL_W-1:0]   ocol;
      logic [3:0]         kr;
      logic [3:0]         kc;
   } cmd_type;

   function automatic logic [3:0] clamp4(input logic [3:0] v, input logic [3:0] hi);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] hi);
      logic [5:0] r;
      r = v;
      if (v == 6'd0) r = 6'd1;
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/mpool_queue.sv
// ----------------------------------------------------------------------------
// mpool_queue
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_queue
   import mpool_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      head
);

   cmd_type    slot_ff [0:1];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         if ((push && !full) && !(pop && !empty)) cnt_ff <= cnt_ff + 2'd1;
         else if (!(push && !full) && (pop && !empty)) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wp_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

FILE: src/mpool_front.sv
// ----------------------------------------------------------------------------
// mpool_front
// accepts items, checks ranges and finds window corners
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_front
   import mpool_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    enable,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         push,
   output cmd_type      push_cmd,
   input  wire logic    full
);

   front_state_type state_ff, state_in;
   req_type         req_ff;
   cmd_type         cmd_ff;
   logic [5:0]      rr_ff, rc_ff;
   logic [ROW_W-1:0] qr_ff;
   logic [COL_W-1:0] qc_ff;

   logic       exceeds, pos_bad;
   logic [5:0] dr, dc;
   logic [7:0] rs, cs;
   op_type     cls_op;
   status_type cls_status;

   assign exceeds = ({2'b0, cfg.kr} > cfg.pr) || ({2'b0, cfg.kc} > cfg.pc);
   assign pos_bad = ({1'b0, req_ff.channel} >= cfg.pn) || ({1'b0, req_ff.row} >= cfg.pr)
                    || ({1'b0, req_ff.col} >= cfg.pc);
   assign dr = {1'b0, req_ff.row} + 6'd1 - {2'b0, cfg.kr};
   assign dc = {1'b0, req_ff.col} + 6'd1 - {2'b0, cfg.kc};
   assign rs = req_ff.row * cfg.st;
   assign cs = req_ff.col * cfg.st;

   assign req_ready = (state_ff == F_IDLE) && enable;
   assign push      = (state_ff == F_PUSH) && !full;
   assign push_cmd  = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (req_valid && req_ready) state_in = F_CLASS;
         F_CLASS: begin
            if (req_ff.action == ACT_NONE) state_in = F_IDLE;
            else if (req_ff.action == ACT_FWD && !pos_bad && !exceeds
                     && {1'b0, req_ff.row} + 6'd1 >= {2'b0, cfg.kr}
                     && {1'b0, req_ff.col} + 6'd1 >= {2'b0, cfg.kc}) state_in = F_DIV;
            else state_in = F_PUSH;
         end
         F_DIV:   if (rr_ff < {2'b0, cfg.st} && rc_ff < {2'b0, cfg.st}) state_in = F_PUSH;
         F_PUSH:  if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      cls_op     = OP_PIX;
      cls_status = ST_OK;
      unique case (req_ff.action)
         ACT_FWD: begin
            if (pos_bad) begin
               cls_op     = OP_ERR;
               cls_status = ST_RANGE;
            end else if (exceeds && {1'b0, req_ff.row} == cfg.pr - 6'd1
                         && {1'b0, req_ff.col} == cfg.pc - 6'd1) begin
               cls_op     = OP_PIX_ERR;
               cls_status = ST_EXCEEDS;
            end
         end
         ACT_BWD: begin
            cls_op = OP_BWD;
            if (exceeds) cls_status = ST_EXCEEDS;
            else if ({1'b0, req_ff.channel} >= cfg.pn
                     || rs > {2'b0, cfg.pr - {2'b0, cfg.kr}}
                     || cs > {2'b0, cfg.pc - {2'b0, cfg.kc}}) cls_status = ST_RANGE;
         end
         ACT_READ: begin
            if (pos_bad) begin
               cls_op     = OP_ERR;
               cls_status = ST_RANGE;
            end else begin
               cls_op = OP_READ;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid && req_ready) req_ff <= req_payload;
      if (state_ff == F_CLASS) begin
         cmd_ff.channel <= req_ff.channel;
         cmd_ff.row     <= req_ff.row;
         cmd_ff.col     <= req_ff.col;
         cmd_ff.sample  <= req_ff.sample;
         cmd_ff.brow    <= dr[ROW_W-1:0];
         cmd_ff.bcol    <= dc[COL_W-1:0];
         cmd_ff.orow    <= '0;
         cmd_ff.ocol    <= '0;
         cmd_ff.kr      <= cfg.kr;
         cmd_ff.kc      <= cfg.kc;
         cmd_ff.status  <= cls_status;
         cmd_ff.op      <= cls_op;
         rr_ff <= dr;
         rc_ff <= dc;
         qr_ff <= '0;
         qc_ff <= '0;
      end
      if (state_ff == F_DIV) begin
         if (rr_ff >= {2'b0, cfg.st}) begin
            rr_ff <= rr_ff - {2'b0, cfg.st};
            qr_ff <= qr_ff + 1'b1;
         end
         if (rc_ff >= {2'b0, cfg.st}) begin
            rc_ff <= rc_ff - {2'b0, cfg.st};
            qc_ff <= qc_ff + 1'b1;
         end
         if (rr_ff < {2'b0, cfg.st} && rc_ff < {2'b0, cfg.st}) begin
            cmd_ff.orow <= qr_ff;
            cmd_ff.ocol <= qc_ff;
            if (rr_ff == 6'd0 && rc_ff == 6'd0) cmd_ff.op <= OP_WALK;
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/mpool_back.sv
// ----------------------------------------------------------------------------
// mpool_back
// plane store, window walk, argmax store and gradient accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_back
   import mpool_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire cmd_type head,
   output logic         pop,
   output logic         ready_for_items,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int PL_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ALL_DEPTH = MAX_CHANNELS * PL_DEPTH;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff;
   logic           done_ff;
   logic [ALL_AW-1:0] clr_ff;

   logic [15:0]        plane_mem [0:PL_DEPTH-1];
   logic [PL_AW-1:0]   argmax_mem [0:ALL_DEPTH-1];
   logic [23:0]        grad_mem [0:ALL_DEPTH-1];
   logic signed [15:0] pl_q_ff;
   logic [PL_AW-1:0]   am_q_ff;
   logic signed [23:0] gr_q_ff;

   logic [KIDX_W-1:0] i_ff, j_ff;
   logic              rdv_ff, first_ff;
   logic [ROW_W-1:0]  rd_row_ff, ar_ff;
   logic [COL_W-1:0]  rd_col_ff, ac_ff;
   logic signed [15:0] best_ff;

   logic               pl_we, am_we, gr_we;
   logic [PL_AW-1:0]   pl_waddr, pl_raddr, am_wdata;
   logic [ALL_AW-1:0]  am_waddr, am_raddr, gr_waddr, gr_raddr;
   logic [23:0]        gr_wdata;
   logic [ROW_W-1:0]   wr_row;
   logic [COL_W-1:0]   wr_col;
   logic               walk_last;
   logic signed [24:0] sum;
   logic signed [23:0] sat;

   assign wr_row    = cmd_ff.brow + {{(ROW_W-KIDX_W){1'b0}}, i_ff};
   assign wr_col    = cmd_ff.bcol + {{(COL_W-KIDX_W){1'b0}}, j_ff};
   assign walk_last = ({1'b0, i_ff} == cmd_ff.kr - 4'd1) && ({1'b0, j_ff} == cmd_ff.kc - 4'd1);
   assign sum = {gr_q_ff[23], gr_q_ff} + {{9{cmd_ff.sample[15]}}, cmd_ff.sample};
   assign sat = (sum > 25'sd8388607) ? ACC_MAX :
                (sum < -25'sd8388608) ? ACC_MIN : sum[23:0];

   assign pop             = (state_ff == B_IDLE) && !empty && !rsp_valid_ff;
   assign ready_for_items = (state_ff != B_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      pl_we    = 1'b0;
      pl_waddr = {cmd_ff.row, cmd_ff.col};
      pl_raddr = {wr_row, wr_col};
      am_we    = 1'b0;
      am_waddr = {cmd_ff.channel, cmd_ff.orow, cmd_ff.ocol};
      am_wdata = {ar_ff, ac_ff};
      am_raddr = {cmd_ff.channel, cmd_ff.row, cmd_ff.col};
      gr_we    = 1'b0;
      gr_waddr = {cmd_ff.channel, am_q_ff};
      gr_wdata = sat;
      gr_raddr = {cmd_ff.channel, am_q_ff};
      unique case (state_ff)
         B_CLEAR: begin
            gr_we    = 1'b1;
            gr_waddr = clr_ff;
            gr_wdata = '0;
            if (&clr_ff) state_in = B_IDLE;
         end
         B_IDLE: if (pop) state_in = B_EXEC;
         B_EXEC: begin
            unique case (cmd_ff.op)
               OP_ERR:     state_in = B_IDLE;
               OP_PIX:     begin pl_we = 1'b1; state_in = B_IDLE; end
               OP_PIX_ERR: begin pl_we = 1'b1; state_in = B_IDLE; end
               OP_WALK:    begin pl_we = 1'b1; state_in = B_WALK; end
               OP_BWD: begin
                  if (done_ff && cmd_ff.status == ST_OK) state_in = B_BWD_A;
                  else state_in = B_IDLE;
               end
               OP_READ: begin
                  gr_raddr = {cmd_ff.channel, cmd_ff.row, cmd_ff.col};
                  state_in = B_RD;
               end
               default: state_in = B_IDLE;
            endcase
         end
         B_WALK:  if (walk_last) state_in = B_WEND;
         B_WEND:  state_in = B_WSAVE;
         B_WSAVE: begin am_we = 1'b1; state_in = B_IDLE; end
         B_BWD_A: state_in = B_BWD_B;
         B_BWD_B: begin gr_we = 1'b1; state_in = B_IDLE; end
         B_RD: begin
            gr_we    = 1'b1;
            gr_waddr = {cmd_ff.channel, cmd_ff.row, cmd_ff.col};
            gr_wdata = '0;
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pl_we) plane_mem[pl_waddr] <= cmd_ff.sample;
      pl_q_ff <= plane_mem[pl_raddr];
   end

   always_ff @(posedge clock) begin
      if (am_we) argmax_mem[am_waddr] <= am_wdata;
      am_q_ff <= argmax_mem[am_raddr];
   end

   always_ff @(posedge clock) begin
      if (gr_we) grad_mem[gr_waddr] <= gr_wdata;
      gr_q_ff <= grad_mem[gr_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
         rdv_ff <= (state_ff == B_WALK);
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == B_WSAVE) done_ff <= 1'b1;
         if ((state_ff == B_EXEC && (cmd_ff.op == OP_ERR || cmd_ff.op == OP_PIX_ERR
              || (cmd_ff.op == OP_BWD && !(done_ff && cmd_ff.status == ST_OK))))
             || state_ff == B_WSAVE || state_ff == B_BWD_B || state_ff == B_RD)
            rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop) cmd_ff <= head;
      if (state_ff == B_EXEC) begin
         i_ff     <= '0;
         j_ff     <= '0;
         first_ff <= 1'b1;
      end
      if (state_ff == B_WALK) begin
         rd_row_ff <= wr_row;
         rd_col_ff <= wr_col;
         if ({1'b0, j_ff} == cmd_ff.kc - 4'd1) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
      if (rdv_ff) begin
         first_ff <= 1'b0;
         if (first_ff || pl_q_ff > best_ff) begin
            best_ff <= pl_q_ff;
            ar_ff   <= rd_row_ff;
            ac_ff   <= rd_col_ff;
         end
      end
      if (state_ff == B_EXEC) begin
         rsp_ff <= '{status: ((cmd_ff.op == OP_BWD && !done_ff) ? ST_NO_FWD : cmd_ff.status),
                     result_value: '0,
                     res_channel: cmd_ff.channel,
                     win_row: '0,
                     win_col: '0,
                     arg_row: '0,
                     arg_col: '0};
      end
      if (state_ff == B_WSAVE) begin
         rsp_ff.status       <= ST_OK;
         rsp_ff.result_value <= {{8{best_ff[15]}}, best_ff};
         rsp_ff.res_channel  <= cmd_ff.channel;
         rsp_ff.win_row      <= cmd_ff.orow;
         rsp_ff.win_col      <= cmd_ff.ocol;
         rsp_ff.arg_row      <= ar_ff;
         rsp_ff.arg_col      <= ac_ff;
      end
      if (state_ff == B_BWD_B) begin
         rsp_ff.status       <= ST_OK;
         rsp_ff.result_value <= sat;
         rsp_ff.res_channel  <= cmd_ff.channel;
         rsp_ff.win_row      <= cmd_ff.row;
         rsp_ff.win_col      <= cmd_ff.col;
         rsp_ff.arg_row      <= am_q_ff[PL_AW-1:COL_W];
         rsp_ff.arg_col      <= am_q_ff[COL_W-1:0];
      end
      if (state_ff == B_RD) begin
         rsp_ff.status       <= ST_OK;
         rsp_ff.result_value <= gr_q_ff;
         rsp_ff.res_channel  <= cmd_ff.channel;
         rsp_ff.win_row      <= '0;
         rsp_ff.win_col      <= '0;
         rsp_ff.arg_row      <= cmd_ff.row;
         rsp_ff.arg_col      <= cmd_ff.col;
      end
   end

endmodule

`default_nettype wire

FILE: src/max_pool2d_fwd_bwd.sv
// ----------------------------------------------------------------------------
// max_pool2d_fwd_bwd
// 2-d max pooling with argmax, forward and backward, with register port
// ----------------------------------------------------------------------------
// After reset the block clears its 8192 gradient accumulators, one a cycle,
// and takes no item until they are all cleared; register writes are taken at once.
// A forward pixel that completes a window first waits while the front finds
// the window position by repeated subtraction of the step; the back then
// walks the window through the single read port of the plane memory (up to
// 64 reads). A pixel at or past a window corner that completes none goes
// through the same search. A two-entry command queue sits between the
// classifying front and the executing back, and results wait in an output
// register while the front takes the next item.
`default_nettype none

module max_pool2d_fwd_bwd
   import mpool_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [3:0] kr_ff, kc_ff, st_ff, pn_ff;
   logic [5:0] pr_ff, pc_ff;
   cfg_type    cfg;
   logic       push, full, pop, empty, back_ready;
   cmd_type    push_cmd, head;
   reg_index_type idx;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         kr_ff <= 4'd2;
         kc_ff <= 4'd2;
         st_ff <= 4'd2;
         pr_ff <= 6'd32;
         pc_ff <= 6'd32;
         pn_ff <= 4'd8;
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_KROWS:  kr_ff <= pwdata[3:0];
            REG_KCOLS:  kc_ff <= pwdata[3:0];
            REG_STEP:   st_ff <= pwdata[3:0];
            REG_PROWS:  pr_ff <= pwdata[5:0];
            REG_PCOLS:  pc_ff <= pwdata[5:0];
            REG_PCOUNT: pn_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_KROWS:  prdata = {28'd0, kr_ff};
         REG_KCOLS:  prdata = {28'd0, kc_ff};
         REG_STEP:   prdata = {28'd0, st_ff};
         REG_PROWS:  prdata = {26'd0, pr_ff};
         REG_PCOLS:  prdata = {26'd0, pc_ff};
         REG_PCOUNT: prdata = {28'd0, pn_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.kr = clamp4(kr_ff, 4'(MAX_KERNEL));
   assign cfg.kc = clamp4(kc_ff, 4'(MAX_KERNEL));
   assign cfg.st = clamp4(st_ff, 4'(MAX_KERNEL));
   assign cfg.pr = clamp6(pr_ff, 6'(MAX_ROWS));
   assign cfg.pc = clamp6(pc_ff, 6'(MAX_COLS));
   assign cfg.pn = clamp4(pn_ff, 4'(MAX_CHANNELS));

   mpool_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .enable      (back_ready),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_cmd    (push_cmd),
      .full        (full)
   );

   mpool_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   mpool_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head            (head),
      .pop             (pop),
      .ready_for_items (back_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: verif/tb_max_pool2d_fwd_bwd.sv
// ----------------------------------------------------------------------------
// tb_max_pool2d_fwd_bwd
// Self-checking testbench for the 2-d max pooling block. Forward pixels,
// backward gradients and gradient reads are driven over a valid/ready
// channel with random gaps. A behavioral model kept in this file computes
// each expected result, and every result transfer is checked field by field
// in order. Register settings change between phases over the register port.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_max_pool2d_fwd_bwd;
   import mpool_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   max_pool2d_fwd_bwd dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // pooling model state
   logic [3:0]         kr_reg, kc_reg, st_reg, pn_reg;
   logic [5:0]         pr_reg, pc_reg;
   logic signed [15:0] pix_mem [1024];
   bit                 pix_ok  [1024];
   logic [9:0]         arg_mem [8192];
   bit                 arg_ok  [8192];
   logic signed [23:0] acc_mem [8192];
   bit                 fwd_seen;

   rsp_type pool_results [$];
   int      errors;
   bit      no_idle;
   bit      stall_req;
   int      stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int clampi(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void eff_cfg(output int kr, output int kc, output int st,
                                   output int pr, output int pc, output int pn);
      kr = clampi(kr_reg, MAX_KERNEL);
      kc = clampi(kc_reg, MAX_KERNEL);
      st = clampi(st_reg, MAX_KERNEL);
      pr = clampi(pr_reg, MAX_ROWS);
      pc = clampi(pc_reg, MAX_COLS);
      pn = clampi(pn_reg, MAX_CHANNELS);
   endfunction

   // true when the item touches no store entry that was never written
   function automatic bit touches_known(input req_type q);
      int kr, kc, st, pr, pc, pn, r, c, br, bc, i, j;
      eff_cfg(kr, kc, st, pr, pc, pn);
      r = q.row;
      c = q.col;
      if (q.action == ACT_FWD) begin
         if (q.channel >= pn || r >= pr || c >= pc) return 1;
         if (kr > pr || kc > pc) return 1;
         if (r + 1 < kr || c + 1 < kc) return 1;
         if ((r + 1 - kr) % st != 0 || (c + 1 - kc) % st != 0) return 1;
         br = r + 1 - kr;
         bc = c + 1 - kc;
         for (i = 0; i < kr; i++)
            for (j = 0; j < kc; j++)
               if (!(br + i == r && bc + j == c) && !pix_ok[(br + i) * 32 + bc + j])
                  return 0;
      end else if (q.action == ACT_BWD) begin
         if (!fwd_seen || kr > pr || kc > pc) return 1;
         if (q.channel >= pn || r >= (pr - kr) / st + 1 || c >= (pc - kc) / st + 1)
            return 1;
         return arg_ok[q.channel * 1024 + r * 32 + c];
      end
      return 1;
   endfunction

   function automatic void pool_predict(input req_type q, output bit has,
                                        output rsp_type e);
      int kr, kc, st, pr, pc, pn, r, c, s, orow, ocol, br, bc, i, j, ar, ac;
      int best, v, sum, idx;
      eff_cfg(kr, kc, st, pr, pc, pn);
      r = q.row;
      c = q.col;
      s = q.sample;
      e = '0;
      e.res_channel = q.channel;
      has = 1;
      if (q.action == ACT_FWD) begin
         if (q.channel >= pn || r >= pr || c >= pc) begin
            e.status = ST_RANGE;
            return;
         end
         pix_mem[r * 32 + c] = q.sample;
         pix_ok[r * 32 + c] = 1;
         if (kr > pr || kc > pc) begin
            if (r == pr - 1 && c == pc - 1) e.status = ST_EXCEEDS;
            else has = 0;
            return;
         end
         if (r + 1 < kr || c + 1 < kc ||
             (r + 1 - kr) % st != 0 || (c + 1 - kc) % st != 0) begin
            has = 0;
            return;
         end
         orow = (r + 1 - kr) / st;
         ocol = (c + 1 - kc) / st;
         br = orow * st;
         bc = ocol * st;
         best = pix_mem[br * 32 + bc];
         ar = br;
         ac = bc;
         for (i = 0; i < kr; i++)
            for (j = 0; j < kc; j++) begin
               v = pix_mem[(br + i) * 32 + bc + j];
               if (v > best) begin
                  best = v;
                  ar = br + i;
                  ac = bc + j;
               end
            end
         idx = q.channel * 1024 + orow * 32 + ocol;
         arg_mem[idx] = 10'(ar * 32 + ac);
         arg_ok[idx] = 1;
         fwd_seen = 1;
         e.status = ST_OK;
         e.result_value = 24'(best);
         e.win_row = 5'(orow);
         e.win_col = 5'(ocol);
         e.arg_row = 5'(ar);
         e.arg_col = 5'(ac);
      end else if (q.action == ACT_BWD) begin
         if (!fwd_seen) begin
            e.status = ST_NO_FWD;
            return;
         end
         if (kr > pr || kc > pc) begin
            e.status = ST_EXCEEDS;
            return;
         end
         if (q.channel >= pn || r >= (pr - kr) / st + 1 || c >= (pc - kc) / st + 1) begin
            e.status = ST_RANGE;
            return;
         end
         idx = arg_mem[q.channel * 1024 + r * 32 + c];
         ar = idx / 32;
         ac = idx % 32;
         idx = q.channel * 1024 + ar * 32 + ac;
         sum = acc_mem[idx] + s;
         if (sum > 8388607) sum = 8388607;
         if (sum < -8388608) sum = -8388608;
         acc_mem[idx] = 24'(sum);
         e.status = ST_OK;
         e.result_value = 24'(sum);
         e.win_row = q.row;
         e.win_col = q.col;
         e.arg_row = 5'(ar);
         e.arg_col = 5'(ac);
      end else if (q.action == ACT_READ) begin
         if (q.channel >= pn || r >= pr || c >= pc) begin
            e.status = ST_RANGE;
            return;
         end
         idx = q.channel * 1024 + r * 32 + c;
         e.status = ST_OK;
         e.result_value = acc_mem[idx];
         acc_mem[idx] = '0;
         e.arg_row = q.row;
         e.arg_col = q.col;
      end else begin
         has = 0;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pool_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result transfer: %p", rsp_payload);
         end else begin
            want = pool_results.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.result_value !== want.result_value ||
                rsp_payload.res_channel !== want.res_channel ||
                rsp_payload.win_row !== want.win_row ||
                rsp_payload.win_col !== want.win_col ||
                rsp_payload.arg_row !== want.arg_row ||
                rsp_payload.arg_col !== want.arg_col) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   // result side flow control
   always @(posedge clock) begin
      if (stall_req) begin
         stall_left = 400;
         stall_req = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 36);
      end
   end

   task automatic send_req(input req_type q);
      int gap;
      bit has;
      rsp_type e;
      gap = 0;
      if (!no_idle)
         while ($urandom_range(0, 99) < 36) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      pool_predict(q, has, e);
      if (has) pool_results.push_back(e);
   endtask

   task automatic send_fields(input action_type a, input int ch, input int r,
                              input int c, input logic [15:0] s);
      req_type q;
      q.action = a;
      q.channel = 3'(ch);
      q.row = 5'(r);
      q.col = 5'(c);
      q.sample = s;
      send_req(q);
   endtask

   task automatic settle(input int extra);
      req_valid <= 1'b0;
      while (pool_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      settle(150);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 5'(idx) << 2;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_KROWS:  kr_reg = val[3:0];
         REG_KCOLS:  kc_reg = val[3:0];
         REG_STEP:   st_reg = val[3:0];
         REG_PROWS:  pr_reg = val[5:0];
         REG_PCOLS:  pc_reg = val[5:0];
         REG_PCOUNT: pn_reg = val[3:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int kr, input int kc, input int st,
                               input int pr, input int pc, input int pn);
      write_reg(REG_KROWS, kr);
      write_reg(REG_KCOLS, kc);
      write_reg(REG_STEP, st);
      write_reg(REG_PROWS, pr);
      write_reg(REG_PCOLS, pc);
      write_reg(REG_PCOUNT, pn);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_noise();
      req_type q;
      do begin
         q = req_type'(31'($urandom));
         q.sample = rand_sample();
      end while (!touches_known(q));
      send_req(q);
   endtask

   task automatic raster_plane(input int ch, input int rows, input int cols,
                               input int noise_pct);
      int r, c;
      for (r = 0; r < rows; r++)
         for (c = 0; c < cols; c++) begin
            if ($urandom_range(0, 99) < noise_pct) send_noise();
            send_fields(ACT_FWD, ch, r, c, rand_sample());
         end
   endtask

   task automatic test_reset_state();
      send_fields(ACT_BWD, 0, 0, 0, 16'h0100);
      send_fields(ACT_NONE, 5, 3, 3, 16'h1234);
      send_fields(ACT_READ, 7, 31, 31, 16'h0000);
      settle(0);
   endtask

   task automatic test_small_plane();
      logic [15:0] vals [16];
      int i;
      vals = '{16'h7FFF, 16'h8000, 16'h0005, 16'h0005,
               16'h8000, 16'h8000, 16'h0005, 16'h0005,
               16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE,
               16'h0000, 16'h0001, 16'h7FFF, 16'h7FFF};
      set_geometry(2, 2, 2, 4, 4, 2);
      for (i = 0; i < 16; i++) send_fields(ACT_FWD, 0, i / 4, i % 4, vals[i]);
      send_fields(ACT_FWD, 2, 0, 0, 16'h0001);
      send_fields(ACT_FWD, 0, 4, 0, 16'h0001);
      send_fields(ACT_BWD, 0, 1, 1, 16'h7FFF);
      send_fields(ACT_BWD, 0, 2, 0, 16'h0001);
      send_fields(ACT_BWD, 2, 0, 0, 16'h0001);
      for (i = 0; i < 16; i++) send_fields(ACT_READ, 0, i / 4, i % 4, 16'h0000);
      send_fields(ACT_READ, 0, 4, 1, 16'h0000);
      settle(0);
   endtask

   task automatic test_window_exceeds();
      write_reg(REG_KROWS, 8);
      send_fields(ACT_FWD, 0, 0, 0, 16'h0010);
      send_fields(ACT_FWD, 0, 3, 3, 16'h0020);
      send_fields(ACT_BWD, 0, 0, 0, 16'h0001);
      write_reg(REG_KROWS, 2);
   endtask

   task automatic test_saturation();
      int i;
      for (i = 0; i < 258; i++) send_fields(ACT_BWD, 0, 0, 0, 16'h7FFF);
      for (i = 0; i < 4; i++) send_fields(ACT_READ, 0, i / 2, i % 2, 16'h0000);
      for (i = 0; i < 258; i++) send_fields(ACT_BWD, 0, 0, 0, 16'h8000);
      for (i = 0; i < 4; i++) send_fields(ACT_READ, 0, i / 2, i % 2, 16'h0000);
      settle(0);
   endtask

   task automatic test_random_phases();
      int ph, kr, kc, st, pr, pc, pn, ch, nch, r, c, i;
      for (ph = 0; ph < 4; ph++) begin
         set_geometry($urandom_range(0, 5), $urandom_range(1, 5), $urandom_range(1, 4),
                      $urandom_range(1, 7), $urandom_range(2, 7), $urandom_range(1, 8));
         eff_cfg(kr, kc, st, pr, pc, pn);
         nch = (pn < 2) ? pn : 2;
         for (i = 0; i < nch; i++) begin
            ch = (i == 0) ? 0 : $urandom_range(1, pn - 1);
            if (ph == 1 && i == 0) stall_req = 1;
            raster_plane(ch, pr, pc, 15);
            if (kr <= pr && kc <= pc)
               for (r = 0; r <= (pr - kr) / st; r++)
                  for (c = 0; c <= (pc - kc) / st; c++)
                     send_fields(ACT_BWD, ch, r, c, rand_sample());
            for (r = 0; r < pr; r++)
               for (c = 0; c < pc; c++) send_fields(ACT_READ, ch, r, c, 16'h0000);
         end
         for (i = 0; i < 20; i++) send_noise();
         settle(0);
      end
   endtask

   task automatic test_register_extremes();
      int i;
      set_geometry(15, 15, 15, 63, 63, 15);
      no_idle = 1;
      raster_plane(7, 8, 32, 0);
      no_idle = 0;
      for (i = 0; i < 4; i++) send_fields(ACT_BWD, 7, 0, i, rand_sample());
      for (i = 0; i < 30; i++) send_noise();
      set_geometry(0, 0, 0, 0, 0, 0);
      send_fields(ACT_FWD, 0, 0, 0, 16'h8000);
      send_fields(ACT_BWD, 0, 0, 0, 16'h7FFF);
      send_fields(ACT_READ, 0, 0, 0, 16'h0000);
      for (i = 0; i < 30; i++) send_noise();
      settle(0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      kr_reg = 4'd2;
      kc_reg = 4'd2;
      st_reg = 4'd2;
      pr_reg = 6'd32;
      pc_reg = 6'd32;
      pn_reg = 4'd8;
      foreach (acc_mem[i]) acc_mem[i] = '0;
      fwd_seen = 0;
      errors = 0;
      no_idle = 0;
      stall_req = 0;
      stall_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_plane();
      test_window_exceeds();
      test_saturation();
      test_random_phases();
      test_register_extremes();
      settle(200);
      if (errors == 0 && pool_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
